/* rtl/core/assert_macros.svh */
// assertion macro used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

/* rtl/core/aes_pkg.sv */
// aes-128 package: s-boxes, gf helpers, round constants, round functions, pipe types
// no dependencies
package aes_pkg;

    localparam int NumRounds = 10;

    localparam logic [0:0] KeyHighIdx = 1'b0;
    localparam logic [0:0] KeyLowIdx  = 1'b1;

    typedef logic [127:0] block_t;
    typedef logic [31:0]  word_t;

    typedef struct packed {
        logic   valid;
        logic   func;
        block_t data;
    } stage_t;

    localparam logic [7:0] RcTab [0:10] = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08,
        8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};

    localparam logic [7:0] FwdBox [0:255] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

    localparam logic [7:0] InvBox [0:255] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic word_t sub_word(input word_t w);
        return {FwdBox[w[31:24]], FwdBox[w[23:16]], FwdBox[w[15:8]], FwdBox[w[7:0]]};
    endfunction

    // byte b of block, byte 0 at the top
    function automatic logic [7:0] blk_byte(input block_t s, input int b);
        return s[127-8*b -: 8];
    endfunction

    function automatic block_t fwd_round(input block_t s, input logic last);
        block_t t;
        block_t m;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(4*c+r) -: 8] = FwdBox[blk_byte(s, 4*((c+r)&3)+r)];
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[127-32*c -: 8];
            a1 = t[119-32*c -: 8];
            a2 = t[111-32*c -: 8];
            a3 = t[103-32*c -: 8];
            m[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            m[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            m[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            m[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return last ? t : m;
    endfunction

    // inverse round: shift, sub, add key, then inverse mix unless last
    function automatic block_t inv_round(input block_t s, input block_t k, input logic last);
        block_t t;
        block_t m;
        logic [7:0] a [0:3];
        logic [7:0] d2 [0:3];
        logic [7:0] d4 [0:3];
        logic [7:0] d8 [0:3];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(4*((c+r)&3)+r) -: 8] = InvBox[blk_byte(s, 4*c+r)];
        t = t ^ k;
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                a[j] = t[127-32*c-8*j -: 8];
                d2[j] = xt(a[j]);
                d4[j] = xt(d2[j]);
                d8[j] = xt(d4[j]);
            end
            for (int r = 0; r < 4; r++)
                m[127-32*c-8*r -: 8] =
                    (d8[r] ^ d4[r] ^ d2[r]) ^
                    (d8[(r+1)&3] ^ d2[(r+1)&3] ^ a[(r+1)&3]) ^
                    (d8[(r+2)&3] ^ d4[(r+2)&3] ^ a[(r+2)&3]) ^
                    (d8[(r+3)&3] ^ a[(r+3)&3]);
        end
        return last ? t : m;
    endfunction

endpackage

/* rtl/core/aes128_block_cipher.sv */
// aes-128 top level: key registers, schedule and a chain of ten round cells
// depends on aes_pkg, aes_key_sched, aes_round_cell, assert_macros.svh
// pipeline: whitening register followed by 10 round cells
// throughput: one block per cycle; the whole chain stalls only when the output is held
// reset: key registers clear to zero and the zero key is expanded, one round key per cycle
// input is held off after reset or a key write while the keys expand
`include "assert_macros.svh"
module aes128_block_cipher
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // block_low, block_high
    input  logic         s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // result_low, result_high
);

    localparam int NCells = aes_pkg::NumRounds;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [63:0] key_high_next;
    logic [63:0] key_low_next;
    logic        key_busy;
    aes_pkg::block_t [aes_pkg::NumRounds:0] round_keys;
    aes_pkg::stage_t in_reg;
    aes_pkg::stage_t chain [0:NCells];
    logic advance;
    logic out_held;

    always_comb
    begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        if (cfg_we)
        begin
            if (cfg_index == aes_pkg::KeyHighIdx)
                key_high_next = cfg_data;
            else if (cfg_index == aes_pkg::KeyLowIdx)
                key_low_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else
        begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
        end
    end

    aes_key_sched u_sched
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (cfg_we),
        .key        ({key_high_next, key_low_next}),
        .busy       (key_busy),
        .round_keys (round_keys)
    );

    assign advance       = !chain[NCells].valid || m_axis_tready;
    assign s_axis_tready = advance && !key_busy;

    // input cell: whitening with round key 0 or 10
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_reg <= '0;
        else if (advance)
        begin
            in_reg.valid <= s_axis_tvalid && !key_busy;
            in_reg.func  <= s_axis_tuser;
            in_reg.data  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^
                (s_axis_tuser ? round_keys[aes_pkg::NumRounds] : round_keys[0]);
        end
    end

    assign chain[0] = in_reg;

    for (genvar g = 1; g <= NCells; g++)
    begin : g_cell
        aes_round_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .last      (g == NCells),
            .enc_key   (round_keys[g]),
            .dec_key   (round_keys[NCells-g]),
            .prev      (chain[g-1]),
            .stage_out (chain[g])
        );
    end

    assign m_axis_tvalid = chain[NCells].valid;
    assign m_axis_tdata  = {chain[NCells].data[63:0], chain[NCells].data[127:64]};
    assign out_held      = m_axis_tvalid && !m_axis_tready;

    `ASSERT_CLK(a_hold, clk, rst_n, out_held |=> $stable(m_axis_tdata), "held output changed")
    `ASSERT_CLK(a_ready, clk, rst_n, s_axis_tready == (!out_held && !key_busy), "ready mismatch")
    `ASSERT_CLK(a_stall, clk, rst_n, !advance |=> $stable(in_reg), "input cell moved in stall")

endmodule

/* rtl/core/aes_key_sched.sv */
// key schedule: expands the cipher key into 11 round keys, one round key per cycle
// depends on aes_pkg
module aes_key_sched
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        load,
    input  aes_pkg::block_t                             key,
    output logic                                        busy,
    output aes_pkg::block_t [aes_pkg::NumRounds:0]      round_keys
);

    aes_pkg::block_t [aes_pkg::NumRounds:0] rk_reg;
    aes_pkg::block_t work_reg;
    aes_pkg::block_t key_next;
    logic [3:0]      cnt_reg;
    logic            busy_reg;

    // next round key from the previous one
    always_comb
    begin
        aes_pkg::word_t t;
        t = aes_pkg::sub_word({work_reg[23:0], work_reg[31:24]}) ^
            {aes_pkg::RcTab[cnt_reg], 24'h0};
        key_next[127:96] = work_reg[127:96] ^ t;
        key_next[95:64]  = work_reg[95:64] ^ key_next[127:96];
        key_next[63:32]  = work_reg[63:32] ^ key_next[95:64];
        key_next[31:0]   = work_reg[31:0] ^ key_next[63:32];
    end

    // reset starts the expansion of the zero key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rk_reg   <= '0;
            work_reg <= '0;
            cnt_reg  <= 4'd1;
            busy_reg <= 1'b1;
        end
        else if (load)
        begin
            rk_reg[0] <= key;
            work_reg  <= key;
            cnt_reg   <= 4'd1;
            busy_reg  <= 1'b1;
        end
        else if (busy_reg)
        begin
            rk_reg[cnt_reg] <= key_next;
            work_reg        <= key_next;
            cnt_reg         <= cnt_reg + 4'd1;
            if (cnt_reg == 4'(aes_pkg::NumRounds))
                busy_reg <= 1'b0;
        end
    end

    assign round_keys = rk_reg;
    assign busy       = busy_reg;

endmodule

/* rtl/core/aes_round_cell.sv */
// one round cell of the cipher chain, both directions
// depends on aes_pkg
module aes_round_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            last,
    input  aes_pkg::block_t enc_key,
    input  aes_pkg::block_t dec_key,
    input  aes_pkg::stage_t prev,
    output aes_pkg::stage_t stage_out
);

    aes_pkg::stage_t stage_reg;
    aes_pkg::stage_t stage_next;

    always_comb
    begin
        stage_next = prev;
        if (prev.func)
            stage_next.data = aes_pkg::inv_round(prev.data, dec_key, last);
        else
            stage_next.data = aes_pkg::fwd_round(prev.data, last) ^ enc_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (advance)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

/* verif/aes128_block_cipher_test.sv */
// stream test of aes128_block_cipher: encrypt and decrypt beats checked against
// a cipher predictor with its own s-box and key schedule; needs aes128_block_cipher
`timescale 1ns / 100ps
module aes128_block_cipher_test;

    typedef struct packed {
        logic        func;
        logic [63:0] blk_high;
        logic [63:0] blk_low;
    } block_req_t;

    typedef struct packed {
        logic [63:0] res_high;
        logic [63:0] res_low;
    } block_res_t;

    localparam logic [0:0] KeyHighIdx = 1'b0;
    localparam logic [0:0] KeyLowIdx  = 1'b1;
    localparam logic       FuncEnc    = 1'b0;
    localparam logic       FuncDec    = 1'b1;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;

    aes128_block_cipher dut (.*);

    logic [7:0]  sbox_fwd [0:255];
    logic [7:0]  sbox_inv [0:255];
    logic [31:0] sched_words [0:43];
    logic [63:0] cur_key_high;
    logic [63:0] cur_key_low;

    block_req_t  block_req_q [$];
    block_res_t  cipher_out_q [$];
    block_req_t  in_flight;
    int          err_count;
    int          burst_left;
    int          gap_left;
    int          stall_pct;
    int          stall_span;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return acc;
    endfunction

    function automatic void build_sboxes();
        logic [7:0] x;
        logic [7:0] v;
        logic [7:0] y;
        for (int i = 0; i < 256; i++)
        begin
            x = i[7:0];
            v = 8'h01;
            // x^254 is the field inverse, zero maps to zero
            for (int k = 0; k < 254; k++)
                v = gf_mult(v, x);
            if (x == 8'h00)
                v = 8'h00;
            y = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                ^ {v[3:0], v[7:4]} ^ 8'h63;
            sbox_fwd[i] = y;
            sbox_inv[y] = x;
        end
    endfunction

    function automatic void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        sched_words[0] = cur_key_high[63:32];
        sched_words[1] = cur_key_high[31:0];
        sched_words[2] = cur_key_low[63:32];
        sched_words[3] = cur_key_low[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            t = sched_words[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {sbox_fwd[t[31:24]], sbox_fwd[t[23:16]], sbox_fwd[t[15:8]],
                     sbox_fwd[t[7:0]]} ^ {rc, 24'h0};
                rc = gf_mult(rc, 8'h02);
            end
            sched_words[i] = sched_words[i-4] ^ t;
        end
    endfunction

    function automatic logic [127:0] add_round_key(input logic [127:0] st, input int rnd);
        return st ^ {sched_words[4*rnd], sched_words[4*rnd+1], sched_words[4*rnd+2],
                     sched_words[4*rnd+3]};
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] st, input logic inv);
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            o[127-8*i -: 8] = inv ? sbox_inv[st[127-8*i -: 8]] : sbox_fwd[st[127-8*i -: 8]];
        return o;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] st, input logic inv);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (inv)
                    o[127-8*(4*((c+r)%4)+r) -: 8] = st[127-8*(4*c+r) -: 8];
                else
                    o[127-8*(4*c+r) -: 8] = st[127-8*(4*((c+r)%4)+r) -: 8];
        return o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] st, input logic inv);
        logic [127:0] o;
        logic [7:0]   coef [0:3];
        logic [7:0]   acc;
        if (inv)
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_mult(st[127-8*(4*c+k) -: 8], coef[(k-r+4)%4]);
                o[127-8*(4*c+r) -: 8] = acc;
            end
        return o;
    endfunction

    function automatic block_res_t cipher_block(input block_req_t req);
        logic [127:0] st;
        st = {req.blk_high, req.blk_low};
        if (req.func == FuncEnc)
        begin
            st = add_round_key(st, 0);
            for (int rnd = 1; rnd < 10; rnd++)
                st = add_round_key(mix_columns(shift_rows(sub_bytes(st, 1'b0), 1'b0),
                                               1'b0), rnd);
            st = add_round_key(shift_rows(sub_bytes(st, 1'b0), 1'b0), 10);
        end
        else
        begin
            st = add_round_key(st, 10);
            for (int rnd = 9; rnd > 0; rnd--)
                st = mix_columns(add_round_key(sub_bytes(shift_rows(st, 1'b1), 1'b1), rnd),
                                 1'b1);
            st = add_round_key(sub_bytes(shift_rows(st, 1'b1), 1'b1), 0);
        end
        return '{res_high: st[127:64], res_low: st[63:0]};
    endfunction

    // sender: bursts and gaps, holds a beat until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (s_axis_tvalid)
                cipher_out_q.push_back(cipher_block(in_flight));
            if (gap_left > 0)
            begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (block_req_q.size() > 0)
            begin
                in_flight = block_req_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {in_flight.blk_low, in_flight.blk_high};
                s_axis_tuser  <= in_flight.func;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver stall pattern: the stall percentage is redrawn whenever its span counter runs out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_pct     <= 0;
            stall_span    <= 0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_span <= $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 20;
                    2: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end
            else
                stall_span <= stall_span - 1;
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // output checker
    always @(posedge clk)
    begin
        block_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cipher_out_q.size() == 0)
            begin
                $error("output beat with no block outstanding: %h", m_axis_tdata);
                err_count++;
            end
            else
            begin
                want = cipher_out_q.pop_front();
                if (m_axis_tdata[63:0] !== want.res_high)
                begin
                    $error("result_high expected %h actual %h", want.res_high,
                           m_axis_tdata[63:0]);
                    err_count++;
                end
                if (m_axis_tdata[127:64] !== want.res_low)
                begin
                    $error("result_low expected %h actual %h", want.res_low,
                           m_axis_tdata[127:64]);
                    err_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        @(posedge clk);
        while (block_req_q.size() > 0 || s_axis_tvalid || cipher_out_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_key(input logic [63:0] khi, input logic [63:0] klo);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= KeyHighIdx;
        cfg_data  <= khi;
        @(posedge clk);
        cfg_index <= KeyLowIdx;
        cfg_data  <= klo;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_key_high = khi;
        cur_key_low  = klo;
        expand_schedule();
        repeat (3) @(posedge clk);
    endtask

    task automatic queue_block(input logic f, input logic [63:0] bh, input logic [63:0] bl);
        block_req_q.push_back('{func: f, blk_high: bh, blk_low: bl});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_random(input int n);
        logic [63:0] bh;
        logic [63:0] bl;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0: begin bh = '1; bl = rand64(); end
                1: begin bh = rand64(); bl = '0; end
                default: begin bh = rand64(); bl = rand64(); end
            endcase
            queue_block(1'($urandom_range(0, 1)), bh, bl);
        end
    endtask

    initial
    begin
        err_count    = 0;
        cfg_we       = 1'b0;
        cfg_index    = KeyHighIdx;
        cfg_data     = '0;
        cur_key_high = '0;
        cur_key_low  = '0;
        build_sboxes();
        expand_schedule();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // zero key straight out of reset
        queue_block(FuncEnc, '0, '0);
        queue_block(FuncDec, '0, '0);
        queue_block(FuncEnc, '1, '1);
        queue_block(FuncDec, '1, '1);
        wait_drained();

        // standard example vector and its inverse
        write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        queue_block(FuncEnc, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_block(FuncDec, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        queue_block(FuncEnc, '0, '1);
        queue_block(FuncDec, '1, '0);
        queue_block(FuncEnc, 64'h8000000000000000, 64'h0000000000000001);
        wait_drained();

        write_key('1, '1);
        queue_block(FuncEnc, '0, '0);
        queue_block(FuncDec, '0, '0);
        queue_block(FuncEnc, '1, '1);
        queue_block(FuncDec, '1, '1);
        queue_random(150);
        wait_drained();

        for (int ph = 0; ph < 9; ph++)
        begin
            write_key(rand64(), rand64());
            queue_random(160);
            wait_drained();
        end

        write_key('0, '0);
        queue_random(100);
        wait_drained();

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/aes_pkg.sv
rtl/core/aes_key_sched.sv
rtl/core/aes_round_cell.sv
rtl/core/aes128_block_cipher.sv
verif/aes128_block_cipher_test.sv
